@@ rtl/core/fifo_queue_with_search_stats_top_defines.svh @@
// Assertion macros for the search-stats queue.
// Included by the top level; no other dependencies.
`ifndef FIFO_QUEUE_WITH_SEARCH_STATS_TOP_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_STATS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define FQ_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);
`define FQ_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);
`else
`define FQ_ASSERT_IMP(lbl, ant, cons, msg)
`define FQ_ASSERT_NXT(lbl, ant, cons, msg)
`endif

`endif

@@ rtl/core/fqss_pkg.sv @@
// Shared types and constants for the search-stats queue.
// No dependencies.
package fqss_pkg;

    localparam int CMD_W   = 3;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 4;
    localparam int ST_W    = 2;
    localparam int WORD_W  = 32;
    localparam int TOTAL_W = 36;
    localparam int FILL_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ    = 3'd0,
        CMD_DEQ    = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_EDIT   = 3'd4,
        CMD_STATS  = 3'd5,
        CMD_DUMP   = 3'd6
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOIDX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_PEEK,
        RES_SEARCH,
        RES_STATS
    } res_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic      capture;
        logic      do_enq;
        logic      do_deq;
        logic      do_edit;
        logic      rd_head;
        logic      walk_start;
        logic      walk_issue;
        logic      load_result;
        logic      load_elem;
        status_t   result_st;
        res_kind_t result_kind;
    } fq_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic empty;
        logic full;
        logic edit_ok;
        logic walk_end;
        logic rd_pend;
        logic out_free;
    } fq_stat_t;

endpackage

@@ rtl/core/fqss_ctrl.sv @@
// Command sequencer for the search-stats queue.
// Depends on fqss_pkg; drives fqss_dp through fq_cmd_t.
module fqss_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  fqss_pkg::fq_stat_t stat,
    output fqss_pkg::fq_cmd_t  cmd
);
    import fqss_pkg::*;

    state_t    state_reg, state_next;
    status_t   st_reg, st_next;
    res_kind_t kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            kind_reg  <= RES_PLAIN;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        st_next         = st_reg;
        kind_next       = kind_reg;
        cmd             = '0;
        cmd.result_st   = st_reg;
        cmd.result_kind = kind_reg;
        s_tready        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                st_next    = ST_OK;
                kind_next  = RES_PLAIN;
                state_next = S_RESULT;
                if (stat.cmd == CMD_ENQ)
                begin
                    if (stat.full)
                        st_next = ST_FULL;
                    else
                        cmd.do_enq = 1'b1;
                end
                else if (stat.cmd == CMD_DEQ || stat.cmd == CMD_PEEK ||
                         stat.cmd == CMD_SEARCH || stat.cmd == CMD_EDIT ||
                         stat.cmd == CMD_STATS || stat.cmd == CMD_DUMP)
                begin
                    if (stat.empty)
                        st_next = ST_EMPTY;
                    else
                    begin
                        case (stat.cmd)
                            CMD_DEQ:    cmd.do_deq = 1'b1;
                            CMD_PEEK:
                            begin
                                cmd.rd_head = 1'b1;
                                kind_next   = RES_PEEK;
                            end
                            CMD_SEARCH:
                            begin
                                cmd.walk_start = 1'b1;
                                kind_next      = RES_SEARCH;
                                state_next     = S_WALK;
                            end
                            CMD_STATS:
                            begin
                                cmd.walk_start = 1'b1;
                                kind_next      = RES_STATS;
                                state_next     = S_WALK;
                            end
                            CMD_EDIT:
                            begin
                                if (stat.edit_ok)
                                    cmd.do_edit = 1'b1;
                                else
                                    st_next = ST_NOIDX;
                            end
                            CMD_DUMP:
                            begin
                                cmd.walk_start = 1'b1;
                                state_next     = S_DUMP_RD;
                            end
                            default: st_next = ST_OK;
                        endcase
                    end
                end
            end
            S_WALK:
            begin
                cmd.walk_issue = !stat.walk_end;
                if (stat.walk_end && !stat.rd_pend)
                    state_next = S_RESULT;
            end
            S_DUMP_RD:
            begin
                cmd.walk_issue = 1'b1;
                state_next     = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_elem = 1'b1;
                    state_next    = stat.walk_end ? S_IDLE : S_DUMP_RD;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ rtl/core/fqss_dp.sv @@
// Datapath of the search-stats queue: ring store, pointers, walk unit,
// accumulators and result register. Depends on fqss_pkg.
module fqss_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fqss_pkg::fq_cmd_t                     cmd,
    output fqss_pkg::fq_stat_t                    stat,
    input  fqss_pkg::cmd_t                        in_cmd,
    input  logic signed [fqss_pkg::VAL_W-1:0]     value,
    input  logic        [fqss_pkg::POS_W-1:0]     position,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output fqss_pkg::status_t                     status,
    output logic signed [fqss_pkg::WORD_W-1:0]    word,
    output logic                                  found,
    output logic signed [fqss_pkg::TOTAL_W-1:0]   total,
    output logic signed [fqss_pkg::WORD_W-1:0]    smallest,
    output logic signed [fqss_pkg::WORD_W-1:0]    largest,
    output logic        [fqss_pkg::FILL_W-1:0]    fill,
    output logic                                  last
);
    import fqss_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;
    localparam int EA_W  = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic signed [DATA_WIDTH-1:0] mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] rd_data_reg;

    cmd_t                         cmd_reg;
    logic signed [DATA_WIDTH-1:0] val_reg;
    logic        [POS_W-1:0]      pos_reg;

    logic [PTR_W-1:0] head_reg, tail_reg, walk_ptr_reg;
    logic [OCC_W-1:0] occ_reg, walk_cnt_reg;
    logic             rd_pend_reg;

    logic signed [TOTAL_W-1:0]    sum_reg;
    logic signed [DATA_WIDTH-1:0] min_reg, max_reg;
    logic                         hit_reg, first_reg;

    logic                         out_valid_reg;
    status_t                      out_st_reg;
    logic signed [WORD_W-1:0]     out_word_reg, out_min_reg, out_max_reg;
    logic signed [TOTAL_W-1:0]    out_total_reg;
    logic                         out_found_reg, out_last_reg;
    logic [FILL_W-1:0]            out_fill_reg;

    logic [EA_W-1:0]  ea_sum;
    logic [PTR_W-1:0] edit_addr, rd_addr;
    logic             rd_en, out_free, walk_end;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        ea_sum = EA_W'(head_reg) + EA_W'(pos_reg);
        if (ea_sum >= EA_W'(DEPTH))
            ea_sum = ea_sum - EA_W'(DEPTH);
        edit_addr = ea_sum[PTR_W-1:0];
    end

    assign rd_en    = cmd.rd_head || cmd.walk_issue;
    assign rd_addr  = cmd.rd_head ? head_reg : walk_ptr_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign walk_end = (walk_cnt_reg == occ_reg);

    assign stat.cmd      = cmd_reg;
    assign stat.empty    = (occ_reg == '0);
    assign stat.full     = (occ_reg == OCC_W'(DEPTH));
    assign stat.edit_ok  = (CMP_W'(pos_reg) < CMP_W'(occ_reg));
    assign stat.walk_end = walk_end;
    assign stat.rd_pend  = rd_pend_reg;
    assign stat.out_free = out_free;

    // ring store
    always_ff @(posedge clk)
    begin
        if (cmd.do_enq)
            mem[tail_reg] <= val_reg;
        else if (cmd.do_edit)
            mem[edit_addr] <= val_reg;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= in_cmd;
            val_reg <= DATA_WIDTH'(value);
            pos_reg <= position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            occ_reg      <= '0;
            walk_ptr_reg <= '0;
            walk_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.do_enq)
            begin
                tail_reg <= ptr_inc(tail_reg);
                occ_reg  <= occ_reg + 1'b1;
            end
            else if (cmd.do_deq)
            begin
                head_reg <= ptr_inc(head_reg);
                occ_reg  <= occ_reg - 1'b1;
            end
            if (cmd.walk_start)
            begin
                walk_ptr_reg <= head_reg;
                walk_cnt_reg <= '0;
            end
            else if (cmd.walk_issue)
            begin
                walk_ptr_reg <= ptr_inc(walk_ptr_reg);
                walk_cnt_reg <= walk_cnt_reg + 1'b1;
            end
            rd_pend_reg <= cmd.walk_issue;
        end
    end

    // search and stats accumulate one entry per cycle behind the read
    always_ff @(posedge clk)
    begin
        if (cmd.walk_start)
        begin
            sum_reg   <= '0;
            hit_reg   <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (rd_pend_reg)
        begin
            sum_reg   <= sum_reg + TOTAL_W'(rd_data_reg);
            first_reg <= 1'b0;
            if (rd_data_reg == val_reg)
                hit_reg <= 1'b1;
            if (first_reg || rd_data_reg < min_reg)
                min_reg <= rd_data_reg;
            if (first_reg || rd_data_reg > max_reg)
                max_reg <= rd_data_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_result || cmd.load_elem)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result || cmd.load_elem)
        begin
            out_fill_reg <= FILL_W'(occ_reg);
            if (cmd.load_elem)
            begin
                out_st_reg    <= ST_OK;
                out_word_reg  <= WORD_W'(rd_data_reg);
                out_found_reg <= 1'b0;
                out_total_reg <= '0;
                out_min_reg   <= '0;
                out_max_reg   <= '0;
                out_last_reg  <= walk_end;
            end
            else
            begin
                out_st_reg    <= cmd.result_st;
                out_last_reg  <= 1'b1;
                out_word_reg  <= (cmd.result_kind == RES_PEEK) ?
                                 WORD_W'(rd_data_reg) : '0;
                out_found_reg <= (cmd.result_kind == RES_SEARCH) ? hit_reg : 1'b0;
                out_total_reg <= (cmd.result_kind == RES_STATS) ? sum_reg : '0;
                out_min_reg   <= (cmd.result_kind == RES_STATS) ?
                                 WORD_W'(min_reg) : '0;
                out_max_reg   <= (cmd.result_kind == RES_STATS) ?
                                 WORD_W'(max_reg) : '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign status   = out_st_reg;
    assign word     = out_word_reg;
    assign found    = out_found_reg;
    assign total    = out_total_reg;
    assign smallest = out_min_reg;
    assign largest  = out_max_reg;
    assign fill     = out_fill_reg;
    assign last     = out_last_reg;

endmodule

@@ rtl/core/fifo_queue_with_search_stats_top.sv @@
// Bounded ring queue of signed words with peek, search, edit, stats and dump.
// One command at a time. Enqueue, dequeue, peek, edit: accept, execute, then
// result load; the next command is taken after that load. Search and stats
// walk the store's read port one entry per cycle. Dump reads each element,
// then sends it when the output is free. rst_n clears pointers, count
// and handshake state asynchronously; stored words are undefined until written.
module fifo_queue_with_search_stats_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // value[31:0], position[35:32], zero pad
    input  logic [2:0]   s_tuser,   // cmd[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // word[31:0], found[32], total[68:33],
                                    // smallest[100:69], largest[132:101],
                                    // fill[137:133], zero pad
    output logic [1:0]   m_tuser,   // status[1:0]
    output logic         m_tlast
);
    import fqss_pkg::*;
    `include "fifo_queue_with_search_stats_top_defines.svh"

    localparam logic [FILL_W-1:0] FILL_AT_FULL = FILL_W'(DEPTH);

    fq_cmd_t  cmd;
    fq_stat_t stat;

    status_t                   status;
    logic signed [WORD_W-1:0]  word, smallest, largest;
    logic signed [TOTAL_W-1:0] total;
    logic                      found;
    logic [FILL_W-1:0]         fill;

    fqss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fqss_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_cmd   (cmd_t'(s_tuser)),
        .value    (s_tdata[31:0]),
        .position (s_tdata[35:32]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .word     (word),
        .found    (found),
        .total    (total),
        .smallest (smallest),
        .largest  (largest),
        .fill     (fill),
        .last     (m_tlast)
    );

    assign m_tdata = {6'd0, fill, largest, smallest, total, found, word};
    assign m_tuser = status;

    `FQ_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second transaction taken while busy")
    `FQ_ASSERT_IMP(a_full_fill, m_tvalid && m_tuser == ST_FULL, m_tdata[137:133] == FILL_AT_FULL, "full status with queue not full")
    `FQ_ASSERT_IMP(a_empty_fill, m_tvalid && m_tuser == ST_EMPTY, m_tdata[137:133] == '0, "empty status with entries stored")

endmodule
